[rtl/core/hcc_pkg.sv]
// shared constants, types and the hash round for the keystream cipher
// depends on nothing; imported by every module of the block

package hcc_pkg;

   localparam int KEY_BYTES   = 32;
   localparam int NONCE_BYTES = 12;
   localparam int SEED_ROUNDS = KEY_BYTES + NONCE_BYTES;
   localparam int ROUND_W     = $clog2(SEED_ROUNDS);
   localparam int CSR_INDEX_W = 3;

   localparam logic [63:0] LANE_ONE_INIT = 64'h243F6A8885A308D3;
   localparam logic [63:0] LANE_TWO_INIT = 64'h13198A2E03707344;
   localparam logic [63:0] MUL_LOW       = 64'h00000000000001B3;
   localparam int          MUL_HIGH_SH   = 40;
   localparam logic [63:0] GOLDEN        = 64'h9E3779B97F4A7C15;
   localparam int          SH_ONE        = 29;
   localparam int          SH_TWO_LEFT   = 17;
   localparam int          SH_TWO_RIGHT  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD0  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD1  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD2  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD3  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_LOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_HIGH = 3'd5;

   typedef struct packed {
      logic [63:0] one;
      logic [63:0] two;
   } lanes_type;

   localparam lanes_type LANES_INIT = '{one: LANE_ONE_INIT, two: LANE_TWO_INIT};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEED,
      ST_BLOCK,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic               capture;
      logic               seed_init;
      logic               seed_round;
      logic               seed_last;
      logic               block_load;
      logic               block_round;
      logic               emit_direct;
      logic               emit_block;
      logic [ROUND_W-1:0] round_idx;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic pos_zero;
   } status_type;

   // one hash round; the prime is 2^40 + 0x1B3, so the product is a shift and a small constant
   function automatic lanes_type absorb(input lanes_type lanes, input logic [7:0] b);
      lanes_type   res;
      logic [63:0] a;
      logic [63:0] p;
      logic [63:0] c;
      logic [63:0] c1;
      a        = lanes.one ^ {56'd0, b};
      p        = (a << MUL_HIGH_SH) + (a * MUL_LOW);
      res.one  = p ^ (p >> SH_ONE);
      c        = lanes.two + {56'd0, b} + GOLDEN;
      c1       = c ^ (c << SH_TWO_LEFT);
      res.two  = c1 ^ (c1 >> SH_TWO_RIGHT);
      return res;
   endfunction

endpackage

[rtl/core/hcc_ctrl.sv]
// sequencer for seed, block and emit steps of the keystream cipher
// depends on hcc_pkg; drives the datapath through cmd_type

module hcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_first_of_message,
   output logic               req_ready,
   input  hcc_pkg::status_type status,
   output hcc_pkg::cmd_type    cmd
);
   import hcc_pkg::*;

   ctrl_state_type     state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.round_idx = round_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = status.out_free;
            cmd.capture = accept;
            round_in    = '0;
            if (accept) begin
               if (req_first_of_message) begin
                  cmd.seed_init = 1'b1;
                  state_in      = ST_SEED;
               end else if (status.pos_zero) begin
                  cmd.block_load = 1'b1;
                  state_in       = ST_BLOCK;
               end else begin
                  cmd.emit_direct = 1'b1;
               end
            end
         end
         ST_SEED: begin
            cmd.seed_round = 1'b1;
            if (round_ff == ROUND_W'(SEED_ROUNDS - 1)) begin
               cmd.seed_last = 1'b1;
               round_in      = '0;
               state_in      = ST_BLOCK;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         ST_BLOCK: begin
            cmd.block_round = 1'b1;
            if (round_ff[1:0] == 2'd3) begin
               round_in = '0;
               state_in = ST_EMIT;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            cmd.emit_block = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/hcc_datapath.sv]
// key and nonce registers, hash lanes, keystream block and result register
// depends on hcc_pkg; steered by hcc_ctrl through cmd_type

module hcc_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  hcc_pkg::cmd_type                   cmd,
   output hcc_pkg::status_type                status,
   input  logic [7:0]                         req_data_byte,
   input  logic                               csr_write,
   input  logic [hcc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                        csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte
);
   import hcc_pkg::*;

   logic [3:0][63:0] key_ff, key_in;
   logic [63:0]      nonce_low_ff, nonce_low_in;
   logic [31:0]      nonce_high_ff, nonce_high_in;
   lanes_type        seed_ff, seed_in;
   lanes_type        lanes_ff, lanes_in;
   logic [127:0]     stream_ff, stream_in;
   logic [3:0]       pos_ff, pos_in;
   logic [31:0]      counter_ff, counter_in;
   logic [7:0]       data_ff, data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;

   logic [255:0]     key_vec;
   logic [95:0]      nonce_vec;
   logic [3:0]       nonce_idx;
   logic [1:0]       ctr_sel;
   logic [7:0]       seed_byte;
   logic [7:0]       ctr_byte;
   lanes_type        lanes_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
         seed_ff       <= LANES_INIT;
         pos_ff        <= '0;
         counter_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         key_ff        <= key_in;
         nonce_low_ff  <= nonce_low_in;
         nonce_high_ff <= nonce_high_in;
         seed_ff       <= seed_in;
         pos_ff        <= pos_in;
         counter_ff    <= counter_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff    <= lanes_in;
      stream_ff   <= stream_in;
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign key_vec   = key_ff;
   assign nonce_vec = {nonce_high_ff, nonce_low_ff};
   assign nonce_idx = 4'(cmd.round_idx - ROUND_W'(KEY_BYTES));
   assign seed_byte = (cmd.round_idx < ROUND_W'(KEY_BYTES))
                    ? key_vec[cmd.round_idx[4:0]*8 +: 8]
                    : nonce_vec[nonce_idx*8 +: 8];
   // big-endian counter: first round takes the top byte
   assign ctr_sel    = ~cmd.round_idx[1:0];
   assign ctr_byte   = counter_ff[ctr_sel*8 +: 8];
   assign lanes_next = absorb(lanes_ff, cmd.seed_round ? seed_byte : ctr_byte);

   always_comb begin
      key_in        = key_ff;
      nonce_low_in  = nonce_low_ff;
      nonce_high_in = nonce_high_ff;
      seed_in       = seed_ff;
      lanes_in      = lanes_ff;
      stream_in     = stream_ff;
      pos_in        = pos_ff;
      counter_in    = counter_ff;
      data_in       = data_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (csr_write) begin
         case (csr_index)
            CSR_KEY_WORD0:  key_in[0]     = csr_data;
            CSR_KEY_WORD1:  key_in[1]     = csr_data;
            CSR_KEY_WORD2:  key_in[2]     = csr_data;
            CSR_KEY_WORD3:  key_in[3]     = csr_data;
            CSR_NONCE_LOW:  nonce_low_in  = csr_data;
            CSR_NONCE_HIGH: nonce_high_in = csr_data[31:0];
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         data_in = req_data_byte;
      end
      if (cmd.seed_init) begin
         lanes_in   = LANES_INIT;
         counter_in = '0;
         pos_in     = '0;
      end
      if (cmd.seed_round || cmd.block_round) begin
         lanes_in = lanes_next;
      end
      if (cmd.seed_last) begin
         seed_in = lanes_next;
      end
      if (cmd.block_load) begin
         lanes_in = seed_ff;
      end
      if (cmd.emit_direct) begin
         rsp_byte_in  = req_data_byte ^ stream_ff[pos_ff*8 +: 8];
         pos_in       = pos_ff + 4'd1;
         rsp_valid_in = 1'b1;
      end
      if (cmd.emit_block) begin
         stream_in    = {lanes_ff.two, lanes_ff.one};
         rsp_byte_in  = data_ff ^ lanes_ff.one[7:0];
         pos_in       = 4'd1;
         counter_in   = counter_ff + 32'd1;
         rsp_valid_in = 1'b1;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.pos_zero = (pos_ff == 4'd0);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;

endmodule

[rtl/core/hash_counter_keystream_cipher.sv]
// a byte inside a keystream block is in the result register in the cycle after its request
// the first byte of a block runs 4 counter rounds, one per cycle, then the emit step
// the first byte of a message runs 44 seed rounds on the same round unit first
// throughput: one byte per cycle within a block while the result is taken, none during a block start
// synchronous active-high reset: key and nonce zero, seed at the empty-hash value, counter zero
// depends on hcc_pkg, hcc_ctrl and hcc_datapath

module hash_counter_keystream_cipher (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_first_of_message,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hcc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                     csr_data
);
   import hcc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   hcc_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_first_of_message (req_first_of_message),
      .req_ready            (req_ready),
      .status               (status),
      .cmd                  (cmd)
   );

   hcc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data_byte (req_data_byte),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte)
   );

`ifndef NO_ASSERTIONS
   // a stalled result blocks new requests
   a_no_req_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request taken while result stalled");

   // a message start runs the seed pass before anything else is taken
   a_seed_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_first_of_message) |=> !req_ready)
      else $error("request taken during seed pass");

   // the first byte of a message reaches the result register after seed and block rounds
   a_seed_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_first_of_message) |-> ##(SEED_ROUNDS + 6) rsp_valid)
      else $error("message start result missing");

   // one command at most steers the lanes in a cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.seed_init, cmd.seed_round, cmd.block_load, cmd.block_round,
                cmd.emit_direct, cmd.emit_block}))
      else $error("conflicting datapath commands");
`endif

endmodule
